// ===== hdl/dedp_pkg.sv =====
// ----------------------------------------------------------------------------
// dedp_pkg
// shared constants and types of the density plotter
// ----------------------------------------------------------------------------
`default_nettype none
package dedp_pkg;
   localparam int FrameWidth  = 640;
   localparam int FrameHeight = 480;
   localparam int PixCount    = FrameWidth * FrameHeight;
   localparam int AddrW       = 19;
   localparam int SampleW     = 17;

   localparam logic [1:0] OP_PLOT    = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   localparam logic [2:0] CSR_SCALE_X  = 3'd0;
   localparam logic [2:0] CSR_SCALE_YZ = 3'd1;
   localparam logic [2:0] CSR_SIN      = 3'd2;
   localparam logic [2:0] CSR_COS      = 3'd3;
   localparam logic [2:0] CSR_SHIFT_X  = 3'd4;
   localparam logic [2:0] CSR_SHIFT_Y  = 3'd5;

   // classified job passed from front to back
   typedef struct packed {
      logic             is_plot;  // plot that lands in the frame
      logic             is_read;  // in-frame read and clear
      logic [AddrW-1:0] addr;
   } job_type;

   // pixel result handed to the output
   typedef struct packed {
      logic       hit;
      logic [AddrW-1:0] index;
      logic [7:0] value;
   } res_type;
endpackage
`default_nettype wire

// ===== hdl/delta_embedding_density_plotter_unit.sv =====
// ----------------------------------------------------------------------------
// delta_embedding_density_plotter_unit
// density plotter of sample deltas into an 8-bit pixel store
// ----------------------------------------------------------------------------
// usage
//  - req_ carries one request: opcode, sample, pixel address in tdata
//  - rsp_ returns exactly one result per request: hit, index, pixel value
//  - csr_we high writes a register; user writes only while idle, unchecked
// structure
//  - front: a plot after the first five takes the steps difference, scale
//    multiply, rotate multiply, sum, index multiply; other requests skip them
//  - back: pixel read-modify-write on the single memory port
//  - a two-entry queue lets the front take a new request while the back works
// reset
//  - sample history and counters clear at once
//  - the pixel store is swept clear, one pixel a cycle, all 307200 pixels;
//    requests queue but no result appears until the sweep ends
// stall
//  - a stalled rsp_ holds its result; the queue fills, then req_tready drops
// ----------------------------------------------------------------------------
`default_nettype none
module delta_embedding_density_plotter_unit
   import dedp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // opcode, sample, pixel_address, pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // hit, landed_index, pixel_value, pad
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   logic [31:0] scale_x_ff, scale_yz_ff;
   logic [15:0] sin_ff, cos_ff;
   logic [23:0] shx_ff, shy_ff;
   job_type f_job, q_job;
   logic f_valid, f_ready, q_valid, q_ready;
   res_type res;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff <= 32'd163587; scale_yz_ff <= 32'd122626;
         sin_ff <= '0; cos_ff <= 16'd32767; shx_ff <= '0; shy_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SCALE_X:  scale_x_ff  <= csr_wdata;
            CSR_SCALE_YZ: scale_yz_ff <= csr_wdata;
            CSR_SIN:      sin_ff <= csr_wdata[15:0];
            CSR_COS:      cos_ff <= csr_wdata[15:0];
            CSR_SHIFT_X:  shx_ff <= csr_wdata[23:0];
            CSR_SHIFT_Y:  shy_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   dedp_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_opcode(req_tdata[1:0]), .in_sample(req_tdata[18:2]),
      .in_addr(req_tdata[37:19]),
      .scale_x(scale_x_ff), .scale_yz(scale_yz_ff),
      .sin_a($signed(sin_ff)), .cos_a($signed(cos_ff)),
      .shift_x($signed(shx_ff)), .shift_y($signed(shy_ff)),
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
   );

   dedp_queue u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
   );

   dedp_back u_back (
      .clock, .reset,
      .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
      .res_valid(rsp_tvalid), .res_ready(rsp_tready), .res(res)
   );

   assign rsp_tdata = {4'd0, res.value, res.index, res.hit};
endmodule
`default_nettype wire

// ===== hdl/dedp_front.sv =====
// ----------------------------------------------------------------------------
// dedp_front
// history, coordinate pipeline and hit test; emits pixel jobs
// ----------------------------------------------------------------------------
`default_nettype none
module dedp_front
   import dedp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [1:0]         in_opcode,
   input  wire logic [SampleW-1:0] in_sample,
   input  wire logic [AddrW-1:0]   in_addr,
   input  wire logic [31:0]        scale_x,
   input  wire logic [31:0]        scale_yz,
   input  wire logic signed [15:0] sin_a,
   input  wire logic signed [15:0] cos_a,
   input  wire logic signed [23:0] shift_x,
   input  wire logic signed [23:0] shift_y,
   output logic                    job_valid,
   input  wire logic               job_ready,
   output job_type                 job
);
   localparam logic [2:0] S_IDLE = 3'd0, S_MUL1 = 3'd1, S_MUL2 = 3'd2,
                          S_SUM = 3'd3, S_IDX = 3'd4, S_OUT = 3'd5;
   localparam logic signed [51:0] XC = 52'sd128 * (FrameWidth - 1);
   localparam logic signed [51:0] YC = 52'sd128 * (FrameHeight - 1);
   localparam logic signed [51:0] XM = 52'sd256 * (FrameWidth - 1);
   localparam logic signed [51:0] YM = 52'sd256 * (FrameHeight - 1);

   logic [2:0]  state_ff, state_in;
   logic [SampleW-1:0] p1_ff, p2_ff, p3_ff, p1_in, p2_in, p3_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic signed [17:0] dx_ff, dy_ff, dz_ff;
   logic signed [33:0] x1_ff, y1_ff, z1_ff;
   logic signed [49:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [51:0] xp_ff, yp_ff;
   logic [AddrW-1:0] idx;
   job_type job_ff, job_in;
   logic signed [50:0] px, py, pz;
   logic signed [51:0] xs, ys;
   logic ins;

   assign in_ready  = (state_ff == S_IDLE);
   assign job_valid = (state_ff == S_OUT);
   assign job       = job_ff;

   always_comb begin
      px = dx_ff * $signed({1'b0, scale_x});
      py = dy_ff * $signed({1'b0, scale_yz});
      pz = dz_ff * $signed({1'b0, scale_yz});
      xs = (( pa_ff + pb_ff) >>> 15) + 52'(shift_x) + XC;
      ys = 52'(y1_ff) + ((pc_ff - pd_ff) >>> 16) + 52'(shift_y) + YC;
      ins = (xp_ff >= 0) && (xp_ff <= XM) && (yp_ff >= 0) && (yp_ff <= YM);
      idx = AddrW'(yp_ff[19:8] * 12'(FrameWidth) + 20'(xp_ff[19:8]));
   end

   always_comb begin
      state_in = state_ff;
      p1_in = p1_ff; p2_in = p2_ff; p3_in = p3_ff; cnt_in = cnt_ff;
      job_in = job_ff;
      case (state_ff)
         S_IDLE: if (in_valid) begin
            job_in = '0;
            job_in.addr = in_addr;
            case (in_opcode)
               OP_PLOT: begin
                  p1_in = in_sample; p2_in = p1_ff; p3_in = p2_ff;
                  if (cnt_ff < 3'd5) cnt_in = cnt_ff + 3'd1;
                  state_in = (cnt_ff == 3'd5) ? S_MUL1 : S_OUT;
               end
               OP_READ: begin
                  job_in.is_read = (32'(in_addr) < PixCount);
                  state_in = S_OUT;
               end
               OP_RESTART: begin
                  p1_in = '0; p2_in = '0; p3_in = '0; cnt_in = '0;
                  state_in = S_OUT;
               end
               default: state_in = S_OUT;
            endcase
         end
         S_MUL1: state_in = S_MUL2;
         S_MUL2: state_in = S_SUM;
         S_SUM:  state_in = S_IDX;
         S_IDX: begin
            job_in.is_plot = ins;
            job_in.addr = idx;
            state_in = S_OUT;
         end
         S_OUT: if (job_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         p1_ff <= '0; p2_ff <= '0; p3_ff <= '0; cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         p1_ff <= p1_in; p2_ff <= p2_in; p3_ff <= p3_in; cnt_ff <= cnt_in;
      end
      job_ff <= job_in;
      if (state_ff == S_IDLE) begin
         dx_ff <= $signed({1'b0, in_sample}) - $signed({1'b0, p1_ff});
         dy_ff <= $signed({1'b0, p1_ff}) - $signed({1'b0, p2_ff});
         dz_ff <= $signed({1'b0, p2_ff}) - $signed({1'b0, p3_ff});
      end
      // scaled differences, q.8
      x1_ff <= 34'(px >>> 16);
      y1_ff <= 34'(py >>> 16);
      z1_ff <= 34'(pz >>> 16);
      // rotation products
      pa_ff <= 50'(x1_ff * cos_a);
      pb_ff <= 50'(z1_ff * sin_a);
      pc_ff <= 50'(z1_ff * cos_a);
      pd_ff <= 50'(x1_ff * sin_a);
      xp_ff <= xs;
      yp_ff <= ys;
   end
endmodule
`default_nettype wire

// ===== hdl/dedp_queue.sv =====
// ----------------------------------------------------------------------------
// dedp_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module dedp_queue
   import dedp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_valid,
   output logic         wr_ready,
   input  wire job_type wr_data,
   output logic         rd_valid,
   input  wire logic    rd_ready,
   output job_type      rd_data
);
   job_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic wr, rd;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(wr) - 2'(rd);
      end
      if (wr) mem_ff[wp_ff] <= wr_data;
   end
endmodule
`default_nettype wire

// ===== hdl/dedp_back.sv =====
// ----------------------------------------------------------------------------
// dedp_back
// pixel store with clearing pass and read-modify-write
// ----------------------------------------------------------------------------
`default_nettype none
module dedp_back
   import dedp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_valid,
   output logic         job_ready,
   input  wire job_type job,
   output logic         res_valid,
   input  wire logic    res_ready,
   output res_type      res
);
   localparam logic [1:0] S_CLR = 2'd0, S_IDLE = 2'd1, S_RD = 2'd2, S_OUT = 2'd3;
   logic [7:0] mem [PixCount];
   logic [1:0] state_ff;
   logic [AddrW-1:0] clr_ff;
   job_type job_ff;
   logic [7:0] rdata_ff, nv;
   res_type res_ff;

   assign job_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_OUT);
   assign res = res_ff;
   assign nv = (rdata_ff > 8'd245) ? 8'd255 : rdata_ff + 8'd2;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff <= '0;
      end else begin
         case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (32'(clr_ff) == PixCount - 1) state_ff <= S_IDLE;
            end
            S_IDLE: if (job_valid) state_ff <= S_RD;
            S_RD: state_ff <= S_OUT;
            S_OUT: if (res_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
      if (state_ff == S_IDLE && job_valid) job_ff <= job;
      // read issued as the job is taken, data ready for the modify cycle
      if (state_ff == S_IDLE) rdata_ff <= mem[job.addr];
      if (state_ff == S_CLR) mem[clr_ff] <= 8'd0;
      else if (state_ff == S_RD && job_ff.is_plot) mem[job_ff.addr] <= nv;
      else if (state_ff == S_RD && job_ff.is_read) mem[job_ff.addr] <= 8'd0;
      if (state_ff == S_RD) begin
         res_ff.hit   <= job_ff.is_plot;
         res_ff.index <= job_ff.is_plot ? job_ff.addr : '0;
         res_ff.value <= job_ff.is_plot ? nv : (job_ff.is_read ? rdata_ff : 8'd0);
      end
   end
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench of the delta embedding density plotter: an own pixel
// store and sample history predict every result, compared field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// expected results in request order
class plot_scoreboard;
   bit [27:0] pending[$];
   int        errors;
   int        checked;

   function void note(bit [27:0] r);
      pending.push_back(r);
   endfunction

   function void check(bit [27:0] got);
      bit [27:0] want;
      if (pending.size() == 0) begin
         $display("%0t unexpected result: expected none actual %h", $time, got);
         errors++;
         return;
      end
      want = pending.pop_front();
      checked++;
      if (got[0] !== want[0]) begin
         $display("%0t hit mismatch: expected %0d actual %0d", $time, want[0], got[0]);
         errors++;
      end
      if (got[19:1] !== want[19:1]) begin
         $display("%0t index mismatch: expected %0d actual %0d",
                  $time, want[19:1], got[19:1]);
         errors++;
      end
      if (got[27:20] !== want[27:20]) begin
         $display("%0t value mismatch: expected %0d actual %0d",
                  $time, want[27:20], got[27:20]);
         errors++;
      end
   endfunction
endclass

module testbench;
   import dedp_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   delta_embedding_density_plotter_unit u_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   byte unsigned pix_store[PixCount];
   logic [16:0]  hist_one, hist_two, hist_three;
   int           warm_count;
   logic [31:0]  k_scale_x, k_scale_yz;
   logic signed [15:0] k_sin, k_cos;
   logic signed [23:0] k_shift_x, k_shift_y;

   plot_scoreboard sb = new();
   int  send_idle_pct, recv_stall_pct;
   int  cycle_count = 0;
   int  n_plot, n_hits, n_read, n_restart, n_other;
   localparam int CycleLimit = 3_000_000;

   // floor division by 2^k is an arithmetic shift
   function automatic longint floor_sh(longint v, int k);
      return v >>> k;
   endfunction

   // expected result of one request, updating the predicted state
   function automatic bit [27:0] predict_plot(logic [1:0] op, logic [16:0] s0,
                                              logic [18:0] addr);
      longint dx, dy, dz, x1, y1, z1, xp, yp;
      int     idx;
      bit [27:0] r;
      r = '0;
      case (op)
         OP_PLOT: begin
            n_plot++;
            if (warm_count >= 5) begin
               dx = longint'(s0) - longint'(hist_one);
               dy = longint'(hist_one) - longint'(hist_two);
               dz = longint'(hist_two) - longint'(hist_three);
               x1 = floor_sh(dx * longint'(k_scale_x), 16);
               y1 = floor_sh(dy * longint'(k_scale_yz), 16);
               z1 = floor_sh(dz * longint'(k_scale_yz), 16);
               xp = floor_sh(x1 * k_cos + z1 * k_sin, 15) + k_shift_x
                    + (FrameWidth - 1) * 128;
               yp = y1 + floor_sh(z1 * k_cos - x1 * k_sin, 16) + k_shift_y
                    + (FrameHeight - 1) * 128;
               if (xp >= 0 && xp <= (FrameWidth - 1) * 256 && yp >= 0 &&
                   yp <= (FrameHeight - 1) * 256) begin
                  idx = int'(yp >>> 8) * FrameWidth + int'(xp >>> 8);
                  pix_store[idx] = (pix_store[idx] > 245) ? 8'd255 : pix_store[idx] + 2;
                  r = {pix_store[idx][7:0], idx[18:0], 1'b1};
                  n_hits++;
               end
            end
            hist_three = hist_two;
            hist_two   = hist_one;
            hist_one   = s0;
            if (warm_count < 5) warm_count++;
         end
         OP_READ: begin
            n_read++;
            if (addr < PixCount) begin
               r[27:20] = pix_store[addr];
               pix_store[addr] = 0;
            end
         end
         OP_RESTART: begin
            n_restart++;
            hist_one = '0; hist_two = '0; hist_three = '0;
            warm_count = 0;
         end
         default: n_other++;
      endcase
      return r;
   endfunction

   // valid stays high into the next request unless the sender idles
   task automatic send_request(logic [1:0] op, logic [16:0] s0, logic [18:0] addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, addr, s0, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note(predict_plot(op, s0, addr));
      @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_SCALE_X:  k_scale_x  = val;
         CSR_SCALE_YZ: k_scale_yz = val;
         CSR_SIN:      k_sin      = val[15:0];
         CSR_COS:      k_cos      = val[15:0];
         CSR_SHIFT_X:  k_shift_x  = val[23:0];
         CSR_SHIFT_Y:  k_shift_y  = val[23:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // drop valid, wait for every expected result, then let the unit settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // mostly small steps so that deltas land inside the frame
   task automatic random_burst(int count);
      logic [16:0] s;
      int          pick;
      s = 17'($urandom);
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 78) begin
            if ($urandom_range(9) == 0) s = 17'($urandom);
            else s = s + 17'($urandom_range(0, 60)) - 17'd30;
            send_request(OP_PLOT, s, 19'($urandom));
         end else if (pick < 92) begin
            // mostly in-frame reads, a few addresses past the frame
            send_request(OP_READ, 17'($urandom),
                         ($urandom_range(9) == 0) ? 19'($urandom)
                                                  : 19'($urandom_range(PixCount - 1)));
         end else if (pick < 97) send_request(OP_RESTART, 17'($urandom), 19'($urandom));
         else send_request(2'd3, 17'($urandom), 19'($urandom));
      end
   endtask

   // result side: sample at the rising edge, stall at the falling edge
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check(rsp_tdata[27:0]);

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int ph;
      send_idle_pct = 0; recv_stall_pct = 0;
      foreach (pix_store[i]) pix_store[i] = 0;
      hist_one = '0; hist_two = '0; hist_three = '0; warm_count = 0;
      k_scale_x = 32'd163587; k_scale_yz = 32'd122626;
      k_sin = 16'sd0; k_cos = 16'sd32767; k_shift_x = '0; k_shift_y = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed: warm-up, zero deltas to the centre, saturation, field extremes
      repeat (6) send_request(OP_PLOT, 17'd1000, 19'd0);
      repeat (125) send_request(OP_PLOT, 17'd1000, 19'd0);   // beyond 245 saturates
      send_request(OP_READ, 17'd0, 19'(239 * FrameWidth + 319));
      send_request(OP_READ, 17'd0, 19'(239 * FrameWidth + 319));
      send_request(OP_READ, 17'h1FFFF, 19'h7FFFF);            // past the frame
      send_request(OP_READ, 17'd0, 19'(PixCount - 1));
      send_request(OP_PLOT, 17'h1FFFF, 19'h7FFFF);            // huge jump misses
      send_request(OP_PLOT, 17'd0, 19'd0);
      send_request(OP_RESTART, 17'h1FFFF, 19'h7FFFF);
      send_request(2'd3, 17'h1FFFF, 19'h7FFFF);
      drain();

      // settings phases, extremes included
      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin
               write_reg(CSR_SCALE_X, 32'hFFFF_FFFF); write_reg(CSR_SCALE_YZ, 32'hFFFF_FFFF);
               write_reg(CSR_SIN, 32'h0000_8000);     write_reg(CSR_COS, 32'h0000_7FFF);
               write_reg(CSR_SHIFT_X, 32'h007F_FFFF); write_reg(CSR_SHIFT_Y, 32'h0080_0000);
            end
            1: begin
               write_reg(CSR_SCALE_X, 32'd0);         write_reg(CSR_SCALE_YZ, 32'd0);
               write_reg(CSR_SIN, 32'h0000_7FFF);     write_reg(CSR_COS, 32'h0000_8000);
               write_reg(CSR_SHIFT_X, 32'h0080_0000); write_reg(CSR_SHIFT_Y, 32'h007F_FFFF);
            end
            default: begin
               write_reg(CSR_SCALE_X, $urandom_range(4_000_000));
               write_reg(CSR_SCALE_YZ, $urandom_range(4_000_000));
               write_reg(CSR_SIN, $urandom);
               write_reg(CSR_COS, $urandom);
               write_reg(CSR_SHIFT_X, 32'($signed(24'($urandom_range(40000))) - 20000));
               write_reg(CSR_SHIFT_Y, 32'($signed(24'($urandom_range(40000))) - 20000));
            end
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
         endcase
         random_burst(35);
         // hold off until every result is back, then go on
         req_tvalid <= 1'b0;
         while (sb.pending.size() != 0) @(negedge clock);
         random_burst(35);
         drain();
      end

      $display("covered %0d plots (%0d hits), %0d reads, %0d restarts, %0d unused",
               n_plot, n_hits, n_read, n_restart, n_other);
      $display("%0d results checked over eight register settings", sb.checked);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
hdl/dedp_pkg.sv
hdl/dedp_front.sv
hdl/dedp_queue.sv
hdl/dedp_back.sv
hdl/delta_embedding_density_plotter_unit.sv
test/testbench.sv
